// ===== hdl/life_rule_generation_step_assert.svh =====
// assertion macros shared by the life rule checker
`ifndef LIFE_RULE_GENERATION_STEP_ASSERT_SVH
`define LIFE_RULE_GENERATION_STEP_ASSERT_SVH

// next-cycle property, ignored while reset is asserted
`define LRGS_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

// next-cycle property, checked during reset as well
`define LRGS_ASSERT_NEXT_RST(label, ant, cons, msg) \
  label: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrgs_pkg.sv =====
// shared types, constants and helpers for the life rule generation step
package lrgs_pkg;

  localparam int CFG_DIM_W  = 9;
  localparam int CFG_CNT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BREED_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BREED_MAX   = 3'd5;

  localparam logic [CFG_DIM_W-1:0] RST_GRID_WIDTH  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] RST_GRID_HEIGHT = 9'd256;
  localparam logic [CFG_CNT_W-1:0] RST_LIVE_MIN    = 4'd2;
  localparam logic [CFG_CNT_W-1:0] RST_LIVE_MAX    = 4'd3;
  localparam logic [CFG_CNT_W-1:0] RST_BREED_MIN   = 4'd3;
  localparam logic [CFG_CNT_W-1:0] RST_BREED_MAX   = 4'd3;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // one window column: {bottom, middle, top}
  localparam int COL_W = 3;
  // line buffer entry: {upper row, middle row}
  localparam int LB_W = 2;
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } result_t;

  function automatic logic [1:0] ones3(input logic [COL_W-1:0] v);
    ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

endpackage

// ===== hdl/lrgs_cell.sv =====
// window cell: holds one 3-bit column and passes it to its left neighbour
module lrgs_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift,
  input  logic                     clear,
  input  logic [lrgs_pkg::COL_W-1:0] col_in,
  output logic [lrgs_pkg::COL_W-1:0] col_q
);

  logic [lrgs_pkg::COL_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= clear ? '0 : col_in;
    end
  end

  assign col_q = col_r;

endmodule

// ===== hdl/lrgs_linebuf.sv =====
// two-row line buffer with read forwarding and a clearing pass after reset
module lrgs_linebuf #(
  parameter int DEPTH = lrgs_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [lrgs_pkg::LB_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [lrgs_pkg::LB_W-1:0]  wr_data,
  output logic                       busy
);

  localparam int AW = $clog2(DEPTH);

  logic [lrgs_pkg::LB_W-1:0] mem [DEPTH];
  logic [lrgs_pkg::LB_W-1:0] mem_q_r;
  logic                      fwd_r;
  logic [lrgs_pkg::LB_W-1:0] fwd_data_r;
  logic                      clr_busy_r;
  logic [AW-1:0]             clr_idx_r;

  logic                      we;
  logic [AW-1:0]             wa;
  logic [lrgs_pkg::LB_W-1:0] wd;

  assign we = clr_busy_r || wr_en;
  assign wa = clr_busy_r ? clr_idx_r : wr_addr;
  assign wd = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      // entry being written this cycle is not yet visible in the array
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;
  assign busy    = clr_busy_r;

endmodule

// ===== hdl/lrgs_outq.sv =====
// small result queue that decouples the output stall from the pipeline
module lrgs_outq #(
  parameter int DEPTH = lrgs_pkg::OQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  lrgs_pkg::result_t          push_data,
  input  logic                       pop_stall,
  output logic                       head_valid,
  output lrgs_pkg::result_t          head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(DEPTH + 1);

  lrgs_pkg::result_t q_r   [DEPTH];
  lrgs_pkg::result_t q_nxt [DEPTH];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              pop;
  logic [CW-1:0]     wr_idx;

  assign pop    = (cnt_r != '0) && !pop_stall;
  assign wr_idx = cnt_r - CW'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i + 1 < DEPTH)) begin
        q_nxt[i] = q_r[(i + 1 < DEPTH) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push && (wr_idx == CW'(i))) begin
        q_nxt[i] = push_data;
      end
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = q_r[0];
  assign count      = cnt_r;

endmodule

// ===== hdl/life_rule_generation_step.sv =====
// life rule generation step: one cell per cycle in while in_stall is low; next states
// leave through stage 1, stage 2 and the result queue after acceptance
// throughput: one cell per unstalled cycle, set by the line buffer read/write with forwarding
// reset: config returns to 256x256, survive 2..3, born 3; the line buffer then clears all
// MAX_WIDTH entries with in_stall held high, configuration writes still taken
module life_rule_generation_step #(
  parameter int MAX_WIDTH  = lrgs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lrgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cell_alive,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_next_alive,
  output logic                              out_frame_last,
  input  logic                              cfg_we,
  input  logic [lrgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrgs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CPW = $clog2(MAX_WIDTH);
  localparam int RPW = $clog2(MAX_HEIGHT + 2);
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > lrgs_pkg::CFG_DIM_W) ?
                       $clog2(MAX_WIDTH + 1) : lrgs_pkg::CFG_DIM_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 2) > lrgs_pkg::CFG_DIM_W) ?
                       $clog2(MAX_HEIGHT + 2) : lrgs_pkg::CFG_DIM_W;
  localparam int QCW = $clog2(lrgs_pkg::OQ_DEPTH + 1);
  localparam int QSW = QCW + 1;
  localparam int CNW = lrgs_pkg::CFG_CNT_W;

  typedef struct packed {
    logic bit_alive;
    logic top_en;
    logic mid_en;
    logic emit;
    logic last;
    logic col_zero;
  } s1_flags_t;

  // configuration
  logic [lrgs_pkg::CFG_DIM_W-1:0] grid_width_r;
  logic [lrgs_pkg::CFG_DIM_W-1:0] grid_height_r;
  logic [CNW-1:0]                 live_min_r;
  logic [CNW-1:0]                 live_max_r;
  logic [CNW-1:0]                 breed_min_r;
  logic [CNW-1:0]                 breed_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lrgs_pkg::RST_GRID_WIDTH;
      grid_height_r <= lrgs_pkg::RST_GRID_HEIGHT;
      live_min_r    <= lrgs_pkg::RST_LIVE_MIN;
      live_max_r    <= lrgs_pkg::RST_LIVE_MAX;
      breed_min_r   <= lrgs_pkg::RST_BREED_MIN;
      breed_max_r   <= lrgs_pkg::RST_BREED_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrgs_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        lrgs_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        lrgs_pkg::REG_LIVE_MIN:    live_min_r    <= cfg_wdata[CNW-1:0];
        lrgs_pkg::REG_LIVE_MAX:    live_max_r    <= cfg_wdata[CNW-1:0];
        lrgs_pkg::REG_BREED_MIN:   breed_min_r   <= cfg_wdata[CNW-1:0];
        lrgs_pkg::REG_BREED_MAX:   breed_max_r   <= cfg_wdata[CNW-1:0];
        default: ;
      endcase
    end
  end

  // geometry in use
  logic [WCW-1:0] gw_ext;
  logic [WCW-1:0] wc;
  logic [HCW-1:0] gh_ext;
  logic [HCW-1:0] hc;
  logic [HCW-1:0] hp1;

  always_comb begin
    gw_ext = WCW'(grid_width_r);
    gh_ext = HCW'(grid_height_r);
    if (grid_width_r == '0) begin
      wc = WCW'(1);
    end else if (gw_ext > WCW'(MAX_WIDTH)) begin
      wc = WCW'(MAX_WIDTH);
    end else begin
      wc = gw_ext;
    end
    if (grid_height_r == '0) begin
      hc = HCW'(1);
    end else if (gh_ext > HCW'(MAX_HEIGHT)) begin
      hc = HCW'(MAX_HEIGHT);
    end else begin
      hc = gh_ext;
    end
    hp1 = hc + HCW'(1);
  end

  // raster position and request acceptance
  logic [CPW-1:0] col_pos_r;
  logic [CPW-1:0] col_pos_nxt;
  logic [RPW-1:0] row_pos_r;
  logic [RPW-1:0] row_pos_nxt;
  logic [CPW-1:0] c_eff;
  logic [RPW-1:0] r_eff;
  logic [HCW-1:0] r_ext;
  logic           restart;
  logic           accept;
  s1_flags_t      acc_flags;

  logic           lb_busy;
  logic [QCW-1:0] oq_count;
  logic           s1_valid_r;
  logic           s2_valid_r;
  logic [QSW-1:0] in_flight;

  assign in_flight = QSW'(oq_count) + QSW'(s1_valid_r) + QSW'(s2_valid_r);
  assign in_stall  = lb_busy || (in_flight >= QSW'(lrgs_pkg::OQ_DEPTH));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    // a position outside the frame plus padding restarts the frame
    restart = (WCW'(col_pos_r) >= wc) || (HCW'(row_pos_r) > hp1) ||
              ((HCW'(row_pos_r) == hp1) && (col_pos_r != '0));
    c_eff = restart ? '0 : col_pos_r;
    r_eff = restart ? '0 : row_pos_r;
    r_ext = HCW'(r_eff);

    acc_flags.bit_alive = (r_ext < hc) && in_cell_alive;
    acc_flags.top_en    = (r_eff >= RPW'(2));
    acc_flags.mid_en    = (r_eff >= RPW'(1)) && (r_ext <= hc);
    acc_flags.col_zero  = (c_eff == '0);
    acc_flags.emit      = acc_flags.col_zero ? (r_eff >= RPW'(2)) : (r_eff >= RPW'(1));
    acc_flags.last      = acc_flags.col_zero && (r_ext == hp1);

    if (r_ext == hp1) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end else if ((WCW'(c_eff) + WCW'(1)) >= wc) begin
      col_pos_nxt = '0;
      row_pos_nxt = r_eff + RPW'(1);
    end else begin
      col_pos_nxt = c_eff + CPW'(1);
      row_pos_nxt = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (accept) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // stage 1: line buffer data back, build the new column
  s1_flags_t                 s1_r;
  logic [CPW-1:0]            s1_col_r;
  logic [lrgs_pkg::LB_W-1:0] lb_rd_data;
  logic [lrgs_pkg::LB_W-1:0] lb_wr_data;
  logic [lrgs_pkg::COL_W-1:0] new_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r     <= acc_flags;
      s1_col_r <= c_eff;
    end
  end

  lrgs_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (c_eff),
    .rd_data (lb_rd_data),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (lb_wr_data),
    .busy    (lb_busy)
  );

  // upper row takes the old middle bit unmasked, middle row takes the new cell
  assign lb_wr_data = {lb_rd_data[0], s1_r.bit_alive};
  assign new_col    = {s1_r.bit_alive,
                       s1_r.mid_en && lb_rd_data[0],
                       s1_r.top_en && lb_rd_data[1]};

  // window cells, shifted once per request
  logic                       prev_cz_r;
  logic [lrgs_pkg::COL_W-1:0] win0_q;
  logic [lrgs_pkg::COL_W-1:0] win1_q;
  logic [lrgs_pkg::COL_W-1:0] win2_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cz_r <= 1'b0;
    end else if (s1_valid_r) begin
      prev_cz_r <= s1_r.col_zero;
    end
  end

  // the left column is dead on the second cell of a row
  lrgs_cell u_cell0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_valid_r),
    .clear  (prev_cz_r),
    .col_in (win1_q),
    .col_q  (win0_q)
  );

  lrgs_cell u_cell1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_valid_r),
    .clear  (1'b0),
    .col_in (win2_q),
    .col_q  (win1_q)
  );

  lrgs_cell u_cell2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (s1_valid_r),
    .clear  (1'b0),
    .col_in (new_col),
    .col_q  (win2_q)
  );

  // stage 2: neighbour count and rule
  logic                       s2_emit_r;
  logic                       s2_last_r;
  logic                       s2_cz_r;
  logic [lrgs_pkg::COL_W-1:0] right_col;
  logic                       center;
  logic [CNW-1:0]             ncount;
  logic                       next_state;
  lrgs_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_emit_r <= s1_r.emit;
      s2_last_r <= s1_r.last;
      s2_cz_r   <= s1_r.col_zero;
    end
  end

  always_comb begin
    // first column of a row closes the previous row: right neighbour is outside
    right_col = s2_cz_r ? '0 : win2_q;
    center    = win1_q[1];
    ncount    = CNW'(lrgs_pkg::ones3(win0_q)) + CNW'(lrgs_pkg::ones3(win1_q)) +
                CNW'(lrgs_pkg::ones3(right_col)) - CNW'(center);
    if (center) begin
      next_state = (ncount >= live_min_r) && (ncount <= live_max_r);
    end else begin
      next_state = (ncount >= breed_min_r) && (ncount <= breed_max_r);
    end
    res.next_alive = next_state;
    res.frame_last = s2_last_r;
  end

  lrgs_pkg::result_t head;

  lrgs_outq #(
    .DEPTH (lrgs_pkg::OQ_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s2_valid_r && s2_emit_r),
    .push_data  (res),
    .pop_stall  (out_stall),
    .head_valid (out_valid),
    .head_data  (head),
    .count      (oq_count)
  );

  assign out_next_alive = head.next_alive;
  assign out_frame_last = head.frame_last;

endmodule

// ===== hdl/lrgs_checker.sv =====
// port-level checks for the life rule generation step, bound to the top level
`include "life_rule_generation_step_assert.svh"

module lrgs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_next_alive,
  input logic out_frame_last
);

  logic       out_held;
  logic [1:0] out_pay;

  assign out_held = out_valid && out_stall;
  assign out_pay  = {out_next_alive, out_frame_last};

  // result held while stalled
  `LRGS_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result dropped while stalled")
  `LRGS_ASSERT_NEXT(a_out_stable, out_held, $stable(out_pay), "result changed while stalled")

  // reset empties the result queue and starts the line buffer clearing pass
  `LRGS_ASSERT_NEXT_RST(a_rst_empty, !rst_n, !out_valid, "result present after reset")
  `LRGS_ASSERT_NEXT_RST(a_rst_stall, !rst_n, in_stall, "input taken during line buffer clear")

endmodule

bind life_rule_generation_step lrgs_checker u_lrgs_checker (.*);
